// File: hdl/arpr_pkg.sv
// Shared types, constants and field layouts of the address resolution engine.
`timescale 1ns / 1ps
`default_nettype none

package arpr_pkg;

	// Table sizes.
	localparam int CACHE_ENTRIES = 16;
	localparam int PENDING_DEPTH = 16;
	localparam int CACHE_AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);

	// Fixed values.
	localparam logic [21:0] TIMER_MAX = 22'h3FFFFF;
	localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETHTYPE_ARP = 16'h0806;
	localparam logic [15:0] OPC_REQUEST = 16'd1;
	localparam logic [15:0] OPC_REPLY = 16'd2;
	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
	localparam logic [19:0] LIFETIME_RST = 20'd30000;
	localparam logic [19:0] HOLD_RST = 20'd5000;

	// Configuration register indexes.
	localparam logic [1:0] REG_MY_MAC = 2'd0;
	localparam logic [1:0] REG_MY_IP = 2'd1;
	localparam logic [1:0] REG_LIFETIME = 2'd2;
	localparam logic [1:0] REG_HOLD = 2'd3;

	// Input commands.
	localparam logic [1:0] CMD_SEND = 2'd0;
	localparam logic [1:0] CMD_RECV = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_FRAME   = 3'd0,
		KIND_REQUEST = 3'd1,
		KIND_REPLY   = 3'd2,
		KIND_DELIVER = 3'd3,
		KIND_DROPPED = 3'd4,
		KIND_NONE    = 3'd5
	} kind_t;

	// Input tdata layout, last field listed in the lowest bits.
	typedef struct packed {
		logic [2:0]  pad;
		logic [19:0] elapsed_ms;
		logic [31:0] arp_target_ip;
		logic [47:0] arp_sender_mac;
		logic [31:0] arp_sender_ip;
		logic [15:0] arp_opcode;
		logic        payload_ok;
		logic [47:0] frame_dst_mac;
		logic [15:0] ethertype;
		logic [15:0] dgram_handle;
		logic [31:0] hop_ip;
	} in_data_t;

	// Output tdata layout, last field listed in the lowest bits.
	typedef struct packed {
		logic [15:0] out_handle;
		logic [31:0] arp_target_addr;
		logic [47:0] dst_mac;
	} out_data_t;

	// One result with its kind.
	typedef struct packed {
		kind_t     kind;
		out_data_t data;
	} result_t;

	// Word of the cache memory.
	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [21:0] timer;
	} cache_word_t;

	// Word of the pending queue memory.
	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] handle;
	} pend_word_t;

endpackage

`default_nettype wire

// File: hdl/arpr_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module arpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/arp_resolver_with_pending_queue_core.sv
// Top level of the address resolution engine with its queue of waiting datagrams.
//
//  channel   | direction | tdata                         | tuser | tlast
//  s_axis    | in        | in_data_t (hop_ip first)      | cmd   | -
//  m_axis    | out       | out_data_t (dst_mac first)    | kind  | last result of an item
//  cfg       | in        | cfg_wdata, index cfg_addr     | -     | -
//
// One item at a time. A lookup walks the cache memory entry by entry, a read state then a
// compare state, until a match or the last entry; a tick reads each entry and writes back
// the aged timer of each valid one; a release walks the pending queue, reading and then
// comparing each queued datagram, and ends with a read state that sets the queue count.
// The cache and queue memories have a registered read port, which paces these walks.
// Reset clears valid and pending marks and the queue count at once; no clearing pass.
// A stalled m_axis holds the engine only when a new result has nowhere to go.
`timescale 1ns / 1ps
`default_nettype none

module arp_resolver_with_pending_queue_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// hop_ip, dgram_handle, ethertype, frame_dst_mac, payload_ok, arp_opcode,
	// arp_sender_ip, arp_sender_mac, arp_target_ip, elapsed_ms, zero fill
	input  wire logic [263:0]             s_axis_tdata,
	// cmd
	input  wire logic [1:0]               s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// dst_mac, arp_target_addr, out_handle
	output logic      [95:0]              m_axis_tdata,
	// kind
	output logic      [2:0]               m_axis_tuser,
	output logic                          m_axis_tlast,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_addr,
	input  wire logic [47:0]              cfg_wdata
);

	import arpr_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE      = 13'b0000000000001,
		ST_LK_RD     = 13'b0000000000010,
		ST_LK_CMP    = 13'b0000000000100,
		ST_SEND_ACT  = 13'b0000000001000,
		ST_PUSH      = 13'b0000000010000,
		ST_ARP_LEARN = 13'b0000000100000,
		ST_ARP_REPLY = 13'b0000001000000,
		ST_REL_RD    = 13'b0000010000000,
		ST_REL_CMP   = 13'b0000100000000,
		ST_DELIVER   = 13'b0001000000000,
		ST_TK_RD     = 13'b0010000000000,
		ST_TK_WR     = 13'b0100000000000,
		ST_FINISH    = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [47:0] my_mac_q;
	logic [31:0] my_ip_q;
	logic [19:0] lifetime_q;
	logic [19:0] hold_q;

	// Item being worked on.
	in_data_t    in_q;
	in_data_t    in_d;
	logic [1:0]  cmd_q;
	logic [31:0] key_q;

	// Cache flags and walk state.
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [CACHE_ENTRIES-1:0] pend_q;
	logic [CACHE_AW-1:0]      idx_q;
	logic                     hit_q;
	logic [CACHE_AW-1:0]      hit_idx_q;
	logic                     hit_pend_q;
	logic [47:0]              hit_mac_q;
	logic                     learned_q;

	// Queue state.
	logic [PEND_CW-1:0] count_q;
	logic [PEND_CW-1:0] rel_i_q;
	logic [PEND_CW-1:0] rel_k_q;

	// Held result and output register.
	logic    hold_v_q;
	result_t held_q;
	logic    m_valid_q;
	result_t m_res_q;
	logic    m_last_q;

	// Memory ports.
	logic                cache_we;
	logic [CACHE_AW-1:0] cache_waddr;
	cache_word_t         cache_wdata;
	cache_word_t         cache_rdata;
	logic                pq_we;
	logic [PEND_AW-1:0]  pq_waddr;
	pend_word_t          pq_wdata;
	pend_word_t          pq_rdata;

	// Decisions.
	logic                free_found;
	logic [CACHE_AW-1:0] free_idx;
	logic                lk_match;
	logic                idx_last;
	logic                emit_req;
	result_t             emit_rec;
	logic                out_free;
	logic                emit_ok;
	logic                go;
	logic                out_load;
	logic                send_alloc;
	logic                learn_ok;
	logic                rel_match;
	logic [22:0]         tk_sum;
	logic [21:0]         tk_time;
	logic [19:0]         tk_limit;
	logic                tk_expire;

	assign in_d = in_data_t'(s_axis_tdata);

	arpr_ram #(.WIDTH($bits(cache_word_t)), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
		.clk   (clk),
		.we    (cache_we),
		.waddr (cache_waddr),
		.wdata (cache_wdata),
		.raddr (idx_q),
		.rdata (cache_rdata)
	);

	arpr_ram #(.WIDTH($bits(pend_word_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
		.clk   (clk),
		.we    (pq_we),
		.waddr (pq_waddr),
		.wdata (pq_wdata),
		.raddr (rel_i_q[PEND_AW-1:0]),
		.rdata (pq_rdata)
	);

	// Lowest free cache entry.
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = CACHE_AW'(i);
			end
		end
	end

	assign lk_match = valid_q[idx_q] && (cache_rdata.ip == key_q);
	assign idx_last = (idx_q == CACHE_AW'(CACHE_ENTRIES - 1));
	assign rel_match = (pq_rdata.ip == in_q.arp_sender_ip);
	assign learn_ok = hit_q || free_found;
	assign send_alloc = !(hit_q && !hit_pend_q) && (count_q < PEND_CW'(PENDING_DEPTH))
		&& !hit_q && free_found;

	// Aging of one entry during a tick.
	assign tk_sum = {1'b0, cache_rdata.timer} + {3'b000, in_q.elapsed_ms};
	assign tk_time = tk_sum[22] ? TIMER_MAX : tk_sum[21:0];
	assign tk_limit = pend_q[idx_q] ? hold_q : lifetime_q;
	assign tk_expire = tk_time >= {2'b00, tk_limit};

	// Result that the current state wants to produce.
	always_comb begin
		emit_req = 1'b0;
		emit_rec = '{kind: KIND_NONE, data: '0};
		case (state_q)
			ST_SEND_ACT: begin
				if (hit_q && !hit_pend_q) begin
					emit_req = 1'b1;
					emit_rec = '{kind: KIND_FRAME,
						data: '{out_handle: in_q.dgram_handle, arp_target_addr: '0,
							dst_mac: hit_mac_q}};
				end else if (count_q >= PEND_CW'(PENDING_DEPTH) || (!hit_q && !free_found)) begin
					emit_req = 1'b1;
					emit_rec = '{kind: KIND_DROPPED,
						data: '{out_handle: in_q.dgram_handle, arp_target_addr: '0,
							dst_mac: '0}};
				end else if (!hit_q) begin
					emit_req = 1'b1;
					emit_rec = '{kind: KIND_REQUEST,
						data: '{out_handle: '0, arp_target_addr: key_q, dst_mac: MAC_BCAST}};
				end
			end
			ST_ARP_LEARN: begin
				if (!learn_ok) begin
					emit_req = 1'b1;
					emit_rec = '{kind: KIND_DROPPED,
						data: '{out_handle: '0, arp_target_addr: in_q.arp_sender_ip,
							dst_mac: in_q.arp_sender_mac}};
				end
			end
			ST_ARP_REPLY: begin
				if (in_q.arp_opcode == OPC_REQUEST && in_q.arp_target_ip == my_ip_q) begin
					emit_req = 1'b1;
					emit_rec = '{kind: KIND_REPLY,
						data: '{out_handle: '0, arp_target_addr: in_q.arp_sender_ip,
							dst_mac: in_q.arp_sender_mac}};
				end
			end
			ST_REL_CMP: begin
				if (rel_match) begin
					emit_req = 1'b1;
					emit_rec = '{kind: KIND_FRAME,
						data: '{out_handle: pq_rdata.handle, arp_target_addr: '0,
							dst_mac: in_q.arp_sender_mac}};
				end
			end
			ST_DELIVER: begin
				emit_req = 1'b1;
				emit_rec = '{kind: KIND_DELIVER,
					data: '{out_handle: in_q.dgram_handle, arp_target_addr: '0, dst_mac: '0}};
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	assign out_free = !m_valid_q || m_axis_tready;
	assign emit_ok = !hold_v_q || out_free;
	assign go = !(emit_req && !emit_ok);
	assign out_load = (go && emit_req && hold_v_q)
		|| (!(go && emit_req) && state_q == ST_FINISH && out_free);

	// Cache memory writes.
	always_comb begin
		cache_we = 1'b0;
		cache_waddr = idx_q;
		cache_wdata = '{ip: in_q.arp_sender_ip, mac: in_q.arp_sender_mac, timer: '0};
		case (state_q)
			ST_SEND_ACT: begin
				cache_we = go && send_alloc;
				cache_waddr = free_idx;
				cache_wdata = '{ip: key_q, mac: '0, timer: '0};
			end
			ST_ARP_LEARN: begin
				cache_we = go && learn_ok;
				cache_waddr = hit_q ? hit_idx_q : free_idx;
			end
			ST_TK_WR: begin
				cache_we = 1'b1;
				cache_wdata = '{ip: cache_rdata.ip, mac: cache_rdata.mac, timer: tk_time};
			end
			default: begin
				cache_we = 1'b0;
			end
		endcase
	end

	// Queue memory writes: append on a send, compact during a release.
	always_comb begin
		pq_we = 1'b0;
		pq_waddr = count_q[PEND_AW-1:0];
		pq_wdata = '{ip: key_q, handle: in_q.dgram_handle};
		case (state_q)
			ST_PUSH: begin
				pq_we = 1'b1;
			end
			ST_REL_CMP: begin
				pq_we = !rel_match;
				pq_waddr = rel_k_q[PEND_AW-1:0];
				pq_wdata = pq_rdata;
			end
			default: begin
				pq_we = 1'b0;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_mac_q <= '0;
			my_ip_q <= '0;
			lifetime_q <= LIFETIME_RST;
			hold_q <= HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MY_MAC:   my_mac_q <= cfg_wdata;
				REG_MY_IP:    my_ip_q <= cfg_wdata[31:0];
				REG_LIFETIME: lifetime_q <= cfg_wdata[19:0];
				REG_HOLD:     hold_q <= cfg_wdata[19:0];
				default:      my_ip_q <= my_ip_q;
			endcase
		end
	end

	// Item payload capture.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			in_q <= in_d;
			key_q <= (s_axis_tuser == CMD_SEND) ? in_d.hop_ip : in_d.arp_sender_ip;
		end
		if (state_q == ST_LK_CMP && lk_match) begin
			hit_idx_q <= idx_q;
			hit_pend_q <= pend_q[idx_q];
			hit_mac_q <= cache_rdata.mac;
		end
		if (go && emit_req) begin
			held_q <= emit_rec;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= CMD_SEND;
			valid_q <= '0;
			pend_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			learned_q <= 1'b0;
			count_q <= '0;
			rel_i_q <= '0;
			rel_k_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= s_axis_tuser;
						idx_q <= '0;
						hit_q <= 1'b0;
						case (s_axis_tuser)
							CMD_SEND: state_q <= ST_LK_RD;
							CMD_RECV: begin
								if (in_d.ethertype == ETHTYPE_IPV4
									&& in_d.frame_dst_mac == my_mac_q
									&& in_d.payload_ok) begin
									state_q <= ST_DELIVER;
								end else if (in_d.ethertype == ETHTYPE_ARP
									&& in_d.payload_ok) begin
									state_q <= ST_LK_RD;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							CMD_TICK: state_q <= ST_TK_RD;
							default:  state_q <= ST_FINISH;
						endcase
					end
				end
				ST_LK_RD: begin
					state_q <= ST_LK_CMP;
				end
				ST_LK_CMP: begin
					if (lk_match || idx_last) begin
						hit_q <= lk_match;
						state_q <= (cmd_q == CMD_SEND) ? ST_SEND_ACT : ST_ARP_LEARN;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_LK_RD;
					end
				end
				ST_SEND_ACT: begin
					if (go) begin
						if (send_alloc) begin
							valid_q[free_idx] <= 1'b1;
							pend_q[free_idx] <= 1'b1;
							state_q <= ST_PUSH;
						end else if (hit_q && hit_pend_q
							&& count_q < PEND_CW'(PENDING_DEPTH)) begin
							state_q <= ST_PUSH;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_PUSH: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_FINISH;
				end
				ST_ARP_LEARN: begin
					if (go) begin
						learned_q <= learn_ok;
						if (learn_ok) begin
							valid_q[cache_waddr] <= 1'b1;
							pend_q[cache_waddr] <= 1'b0;
						end
						state_q <= ST_ARP_REPLY;
					end
				end
				ST_ARP_REPLY: begin
					if (go) begin
						rel_i_q <= '0;
						rel_k_q <= '0;
						state_q <= learned_q ? ST_REL_RD : ST_FINISH;
					end
				end
				ST_REL_RD: begin
					if (rel_i_q == count_q) begin
						count_q <= rel_k_q;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_REL_CMP;
					end
				end
				ST_REL_CMP: begin
					if (go) begin
						if (!rel_match) begin
							rel_k_q <= rel_k_q + 1'b1;
						end
						rel_i_q <= rel_i_q + 1'b1;
						state_q <= ST_REL_RD;
					end
				end
				ST_DELIVER: begin
					if (go) begin
						state_q <= ST_FINISH;
					end
				end
				ST_TK_RD: begin
					if (valid_q[idx_q]) begin
						state_q <= ST_TK_WR;
					end else if (idx_last) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_TK_WR: begin
					if (tk_expire) begin
						valid_q[idx_q] <= 1'b0;
						pend_q[idx_q] <= 1'b0;
					end
					if (idx_last) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_TK_RD;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result holding and output register: a held result goes out once the next one
	// arrives, or with last set when the item is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (go && emit_req) begin
				hold_v_q <= 1'b1;
			end else if (state_q == ST_FINISH && out_free) begin
				hold_v_q <= 1'b0;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (go && emit_req && hold_v_q) begin
			m_res_q <= held_q;
			m_last_q <= 1'b0;
		end else if (!(go && emit_req) && state_q == ST_FINISH && out_free) begin
			m_res_q <= hold_v_q ? held_q : '{kind: KIND_NONE, data: '0};
			m_last_q <= 1'b1;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_res_q.data;
	assign m_axis_tuser = m_res_q.kind;
	assign m_axis_tlast = m_last_q;

endmodule

`default_nettype wire

// File: hdl/arpr_checker.sv
// Port-level checks of the resolution engine and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module arpr_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [95:0]  m_axis_tdata,
	input wire logic [2:0]   m_axis_tuser,
	input wire logic         m_axis_tlast
);

	import arpr_pkg::*;

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// The engine does not take a new item in the cycle after it accepts one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	// Only defined kinds appear.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= 3'(KIND_NONE))
		else $error("undefined result kind");

	// A kind none result is always the only and last one of its item.
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == 3'(KIND_NONE) |-> m_axis_tlast
		&& m_axis_tdata == '0)
		else $error("kind none without last or with data");

endmodule

bind arp_resolver_with_pending_queue_core arpr_checker u_arpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
